// ===== design/rrcd_pkg.sv =====
// Shared types and constants for the random replacement cache directory.
// Holds the controller/datapath command and status words and the victim LFSR step.
// No dependencies.
package rrcd_pkg;

   localparam int FRAMES_DEFAULT = 64;
   localparam int ADDR_W         = 32;
   localparam int FIU_W          = 7;
   localparam int SEED_W         = 32;
   localparam int FRAME_OUT_W    = 6;
   localparam int MISS_W         = 16;
   localparam int CSR_IDX_W      = 1;
   localparam int RSP_DATA_W     = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SEED   = 1'd1;

   localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_run;
      logic hit_commit;
      logic fill_commit;
      logic lfsr_step;
      logic mul_load;
      logic victim_read;
      logic victim_commit;
      logic result_load;
   } rrcd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic match;
      logic scan_miss;
      logic fill_free;
      logic rsp_busy;
   } rrcd_status_type;

   // x^32+x^22+x^2+x+1, shift left, feedback into bit 0
   function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
      logic fb;
      fb = s[31] ^ s[21] ^ s[1] ^ s[0];
      return {s[SEED_W-2:0], fb};
   endfunction

endpackage

// ===== design/rrcd_ctrl.sv =====
// Sequencer of the random replacement cache directory: scan, fill or victim
// replacement, result hand-off. Drives the datapath by command word only.
// Depends on rrcd_pkg.
module rrcd_ctrl
   import rrcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  rrcd_status_type status,
   output rrcd_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_VREAD  = 3'd3;
   localparam logic [2:0] ST_VWAIT  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.match) begin
               cmd.hit_commit = 1'b1;
               state_in       = ST_FINISH;
            end else if (status.scan_miss) begin
               if (status.fill_free) begin
                  cmd.fill_commit = 1'b1;
                  state_in        = ST_FINISH;
               end else begin
                  cmd.lfsr_step = 1'b1;
                  state_in      = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_VREAD;
         end
         ST_VREAD: begin
            cmd.victim_read = 1'b1;
            state_in        = ST_VWAIT;
         end
         ST_VWAIT: begin
            cmd.victim_commit = 1'b1;
            state_in          = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register frees up
            if (!status.rsp_busy) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/rrcd_dpath.sv =====
// Datapath of the random replacement cache directory: tag/dirty memory,
// scan pipeline, fill pointer, victim LFSR and multiplier, result registers.
// Depends on rrcd_pkg.
module rrcd_dpath
   import rrcd_pkg::*;
#(
   parameter int FRAMES = FRAMES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rrcd_cmd_type          cmd,
   output rrcd_status_type       status,
   input  logic [ADDR_W-1:0]     req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SEED_W-1:0]     csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W  = $clog2(FRAMES + 1);
   localparam int IDX_W  = $clog2(FRAMES);
   localparam int PROD_W = SEED_W + CNT_W;
   localparam int ENT_W  = ADDR_W + 1;

   // tag memory, dirty bit on top
   logic [ENT_W-1:0] mem [FRAMES];
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   logic [ENT_W-1:0] mem_q;

   logic [FIU_W-1:0]  frames_ff, frames_in;
   logic [SEED_W-1:0] lfsr_ff, lfsr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              kind_ff, kind_in;
   logic              last_ff, last_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [MISS_W-1:0] miss_run_ff, miss_run_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  victim_ff, victim_in;
   logic              res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]  res_frame_ff, res_frame_in;
   logic              res_evict_ff, res_evict_in;
   logic              res_wb_ff, res_wb_in;
   logic [ADDR_W-1:0] res_wbb_ff, res_wbb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  n_act;
   logic [CNT_W-1:0]  limit;
   logic              scan_issue;
   logic              match;
   logic [CNT_W-1:0]  vsel;
   logic [IDX_W-1:0]  victim_calc;
   logic [MISS_W-1:0] miss_new;

   always_comb begin
      if (frames_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (32'(frames_ff) > FRAMES) begin
         n_act = CNT_W'(FRAMES);
      end else begin
         n_act = CNT_W'(frames_ff);
      end
   end

   // only frames below the fill pointer have ever been written
   assign limit      = (fill_ff < n_act) ? fill_ff : n_act;
   assign match      = rd_vld_ff && (mem_q[ADDR_W-1:0] == addr_ff);
   assign scan_issue = cmd.scan_run && (scan_ff < limit) && !match;

   assign vsel        = prod_ff[SEED_W +: CNT_W];
   assign victim_calc = (vsel >= n_act) ? IDX_W'(n_act - CNT_W'(1)) : IDX_W'(vsel);

   assign status.match     = match;
   assign status.scan_miss = (scan_ff >= limit) && !rd_vld_ff;
   assign status.fill_free = fill_ff < n_act;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_tready;

   assign mem_we    = (cmd.hit_commit && kind_ff) || cmd.fill_commit || cmd.victim_commit;
   assign mem_waddr = cmd.hit_commit  ? rd_idx_ff :
                      cmd.fill_commit ? IDX_W'(fill_ff) : victim_ff;
   assign mem_re    = scan_issue || cmd.victim_read;
   assign mem_raddr = cmd.victim_read ? victim_calc : IDX_W'(scan_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= {kind_ff, addr_ff};
      end
      if (mem_re) begin
         mem_q <= mem[mem_raddr];
      end
   end

   assign miss_new = res_hit_ff ? miss_run_ff :
                     ((miss_run_ff == '1) ? miss_run_ff : miss_run_ff + MISS_W'(1));

   always_comb begin
      frames_in    = frames_ff;
      lfsr_in      = lfsr_ff;
      addr_in      = addr_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      fill_in      = fill_ff;
      miss_run_in  = miss_run_ff;
      scan_in      = scan_ff;
      rd_vld_in    = scan_issue;
      rd_idx_in    = scan_issue ? IDX_W'(scan_ff) : rd_idx_ff;
      prod_in      = prod_ff;
      victim_in    = victim_ff;
      res_hit_in   = res_hit_ff;
      res_frame_in = res_frame_ff;
      res_evict_in = res_evict_ff;
      res_wb_in    = res_wb_ff;
      res_wbb_in   = res_wbb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_FRAMES_IN_USE: frames_in = csr_data[FIU_W-1:0];
            CSR_RANDOM_SEED:   lfsr_in   = (csr_data == '0) ? SEED_W'(1) : csr_data;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         addr_in = req_tdata;
         kind_in = req_tuser;
         last_in = req_tlast;
         scan_in = '0;
      end
      if (scan_issue) begin
         scan_in = scan_ff + CNT_W'(1);
      end

      if (cmd.hit_commit) begin
         res_hit_in   = 1'b1;
         res_frame_in = rd_idx_ff;
         res_evict_in = 1'b0;
         res_wb_in    = 1'b0;
         res_wbb_in   = '0;
      end
      if (cmd.fill_commit) begin
         res_hit_in   = 1'b0;
         res_frame_in = IDX_W'(fill_ff);
         res_evict_in = 1'b0;
         res_wb_in    = 1'b0;
         res_wbb_in   = '0;
         fill_in      = fill_ff + CNT_W'(1);
      end
      if (cmd.lfsr_step) begin
         lfsr_in = lfsr_next(lfsr_ff);
      end
      if (cmd.mul_load) begin
         prod_in = PROD_W'(lfsr_ff) * PROD_W'(n_act);
      end
      if (cmd.victim_read) begin
         victim_in = victim_calc;
      end
      if (cmd.victim_commit) begin
         // victim lies below the fill pointer, so it always held a block
         res_hit_in   = 1'b0;
         res_frame_in = victim_ff;
         res_evict_in = 1'b1;
         res_wb_in    = mem_q[ADDR_W];
         res_wbb_in   = mem_q[ADDR_W] ? mem_q[ADDR_W-1:0] : '0;
      end

      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, miss_new, res_wbb_ff, res_wb_ff, res_evict_ff,
                         !res_hit_ff, FRAME_OUT_W'(res_frame_ff), res_hit_ff};
         miss_run_in  = last_ff ? '0 : miss_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= FIU_RESET;
         lfsr_ff      <= SEED_W'(1);
         fill_ff      <= '0;
         miss_run_ff  <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frames_ff    <= frames_in;
         lfsr_ff      <= lfsr_in;
         fill_ff      <= fill_in;
         miss_run_ff  <= miss_run_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      kind_ff      <= kind_in;
      last_ff      <= last_in;
      rd_idx_ff    <= rd_idx_in;
      prod_ff      <= prod_in;
      victim_ff    <= victim_in;
      res_hit_ff   <= res_hit_in;
      res_frame_ff <= res_frame_in;
      res_evict_ff <= res_evict_in;
      res_wb_ff    <= res_wb_in;
      res_wbb_ff   <= res_wbb_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/random_replacement_cache_directory.sv =====
// Fully associative cache directory with random replacement. One access is taken
// at a time; its tags are scanned one frame per cycle from a single-read-port tag
// memory over the filled active frames, and a hit stops the scan early. A random
// replacement then steps the LFSR, loads the multiplier and reads and commits the
// victim before the result is loaded. The controller returns to idle before the
// next access is taken. The result sits in an output register, so the next access
// is taken while it waits; a result still waiting when the following one is ready
// holds that access until the output frees up.
// No reset pass is needed: only frames below the fill pointer are ever looked at.
module random_replacement_cache_directory
   import rrcd_pkg::*;
#(
   parameter int FRAMES = FRAMES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ADDR_W-1:0]     req_tdata,   // block_addr
   input  logic                  req_tuser,   // kind
   input  logic                  req_tlast,   // last_of_request
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit, frame_index[6], fetch_needed, evicted, writeback_valid,
   // writeback_block[32], request_misses[16], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SEED_W-1:0]     csr_data
);

   rrcd_cmd_type    cmd;
   rrcd_status_type status;

   assign csr_ready = 1'b1;

   rrcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrcd_dpath #(
      .FRAMES (FRAMES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
